/* rtl/led_matrix_pwm_scanner_top_assert.svh */
// Assertion macros used by the LED matrix scanner sequencer.
`ifndef LED_MATRIX_PWM_SCANNER_TOP_ASSERT_SVH
`define LED_MATRIX_PWM_SCANNER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define LMPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk and disabled during reset.
`define LMPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LMPS_ASSERT_IMP(lbl, ante, cons, msg)
`define LMPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/lmps_pkg.sv */
// Shared types and constants of the LED matrix scanner.
package lmps_pkg;

	localparam int LED_W       = 7;
	localparam int LEVEL_W     = 3;
	localparam int COL_W       = 3;
	localparam int ROW_BITS    = 16;
	localparam int ROW_IW      = 4;
	localparam int STORE_DEPTH = 128;
	localparam int STORE_AW    = 7;
	localparam int SCAN_AW     = STORE_AW + 1;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [1:0] PH_PWM    = 2'd0;
	localparam logic [1:0] PH_BLANK  = 2'd1;
	localparam logic [1:0] PH_COLUMN = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DONE
	} lmps_state_t;

	typedef struct packed {
		logic               command;
		logic [LED_W-1:0]   led;
		logic [LEVEL_W-1:0] level;
	} lmps_in_t;

	typedef struct packed {
		logic [COL_W-1:0]    column_address;
		logic [ROW_BITS-1:0] row_drive;
		logic                blanking;
	} lmps_out_t;

	typedef struct packed {
		logic                wr_en;
		logic [STORE_AW-1:0] wr_addr;
		logic [LEVEL_W-1:0]  wr_level;
		logic                rd_en;
		logic [STORE_AW-1:0] rd_addr;
	} lmps_store_req_t;

endpackage

/* rtl/lmps_store.sv */
// Brightness store: one write port, one registered read port, valid bits for reset.
module lmps_store import lmps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lmps_store_req_t     req,
	output logic [LEVEL_W-1:0]  rd_level
);

	logic [LEVEL_W-1:0]     mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	logic [LEVEL_W-1:0]     rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_level;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	// An entry never written since reset reads as level zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_level = rd_vld_q ? rd_data_q : '0;

endmodule

/* rtl/lmps_seq.sv */
// Scan sequencer with the shared level comparator that builds one column's row word.
`include "led_matrix_pwm_scanner_top_assert.svh"
module lmps_seq import lmps_pkg::*; #(
	parameter int COLUMNS = 8,
	parameter int ROWS    = 16,
	parameter int LEVELS  = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  lmps_in_t           req,
	output logic               req_ready,
	input  logic               out_free,
	output logic               res_load,
	output lmps_out_t          res,
	output lmps_store_req_t    store_req,
	input  logic [LEVEL_W-1:0] store_level
);

	localparam int MATRIX = COLUMNS * ROWS;
	localparam int LIMIT  = (MATRIX < STORE_DEPTH) ? MATRIX : STORE_DEPTH;
	localparam int NROWS  = (ROWS < ROW_BITS) ? ROWS : ROW_BITS;

	lmps_state_t         state_q, state_d;
	logic [1:0]          phase_q;
	logic [LEVEL_W-1:0]  step_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_BITS-1:0] rows_q;
	logic                blank_q;
	logic [SCAN_AW-1:0]  addr_q;
	logic [ROW_IW-1:0]   row_q;
	logic                rd_v_s1;
	logic                rd_hit_s1;
	logic [ROW_IW-1:0]   rd_row_s1;

	logic               accept;
	logic               tick;
	logic               scan_issue;
	logic [COL_W:0]     col_inc;
	logic [COL_W-1:0]   col_wrap;
	logic [LEVEL_W-1:0] step_inc;
	logic [LEVEL_W-1:0] level_clamp;

	assign accept   = req_valid & req_ready;
	assign tick     = accept & (req.command == CMD_TICK);
	assign col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
	assign col_wrap = (col_inc >= (COL_W+1)'(COLUMNS)) ? '0 : col_inc[COL_W-1:0];
	assign step_inc = step_q + LEVEL_W'(1);

	always_comb begin
		if ({1'b0, req.level} > (LEVEL_W+1)'(LEVELS)) begin
			level_clamp = LEVEL_W'(LEVELS);
		end else begin
			level_clamp = req.level;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick) begin
					state_d = (phase_q == PH_BLANK) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (row_q == ROW_IW'(NROWS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		scan_issue = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE:   req_ready  = 1'b1;
			ST_SCAN:   scan_issue = 1'b1;
			ST_FINISH: ;
			ST_DONE:   res_load   = out_free;
			default:   ;
		endcase
	end

	always_comb begin
		store_req.wr_en    = accept && (req.command == CMD_STORE)
			&& ({1'b0, req.led} < SCAN_AW'(LIMIT));
		store_req.wr_addr  = req.led;
		store_req.wr_level = level_clamp;
		store_req.rd_en    = scan_issue;
		store_req.rd_addr  = addr_q[STORE_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_PWM;
			step_q    <= '0;
			col_q     <= '0;
			rows_q    <= '0;
			blank_q   <= 1'b0;
			addr_q    <= '0;
			row_q     <= '0;
			rd_v_s1   <= 1'b0;
			rd_hit_s1 <= 1'b0;
			rd_row_s1 <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= scan_issue;
			if (tick) begin
				rows_q  <= '0;
				blank_q <= 1'b0;
				row_q   <= '0;
				unique case (phase_q)
					PH_BLANK: begin
						step_q  <= '0;
						phase_q <= PH_COLUMN;
						blank_q <= 1'b1;
					end
					PH_COLUMN: begin
						col_q   <= col_wrap;
						phase_q <= PH_PWM;
						addr_q  <= SCAN_AW'(col_wrap);
					end
					default: begin
						// The unused fourth phase behaves as the PWM phase.
						step_q <= step_inc;
						if (step_inc >= LEVEL_W'(LEVELS - 1)) begin
							phase_q <= PH_BLANK;
						end
						addr_q <= SCAN_AW'(col_q);
					end
				endcase
			end
			if (scan_issue) begin
				rd_hit_s1 <= addr_q < SCAN_AW'(LIMIT);
				rd_row_s1 <= row_q;
				addr_q    <= addr_q + SCAN_AW'(COLUMNS);
				row_q     <= row_q + ROW_IW'(1);
			end
			// Shared comparator: one row per cycle, in the cycle after that row's read is issued.
			if (rd_v_s1 && rd_hit_s1 && (step_q < store_level)) begin
				rows_q[rd_row_s1] <= 1'b1;
			end
		end
	end

	assign res.column_address = col_q;
	assign res.row_drive      = rows_q;
	assign res.blanking       = blank_q;

	`LMPS_ASSERT_NXT(a_blank_tick_done, tick && (phase_q == PH_BLANK), (state_q == ST_DONE) && blank_q && (rows_q == '0), "blanking tick did not produce an all-off result")
	`LMPS_ASSERT_IMP(a_no_write_busy, state_q != ST_IDLE, !store_req.wr_en, "store written during a scan")
	`LMPS_ASSERT_IMP(a_step_range, state_q == ST_SCAN, step_q <= LEVEL_W'(LEVELS - 1), "pwm step out of range during scan")

endmodule

/* rtl/led_matrix_pwm_scanner_top.sv */
// Top level of the multiplexed LED matrix scanner with brightness PWM.
// The req channel carries one beat per command: a store beat writes the brightness
// level of one LED (clamped to LEVELS, ignored beyond the matrix), a tick beat steps
// the scan through its PWM, blanking and column phases.
// The rsp channel carries one beat per tick: the active column, the row word and
// the blanking flag. Store beats produce no rsp beat.
// A PWM or column tick walks the rows of the active column through one shared level
// comparator, reading the brightness memory at one row per cycle; that single memory
// read port sets how long the tick occupies the block. A blanking tick skips the walk.
// The block takes one beat at a time: req_ready is high only while it is idle.
// The result sits in an output register, so while rsp is stalled the block still
// accepts new beats; a tick that finishes while the register is full waits for it.
// Reset clears the scan phase, step and column and marks every stored level as zero
// through per-entry valid bits, with no clearing pass; req_ready is high right after.
module led_matrix_pwm_scanner_top import lmps_pkg::*; #(
	parameter int COLUMNS = 8,
	parameter int ROWS    = 16,
	parameter int LEVELS  = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  lmps_in_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output lmps_out_t rsp
);

	lmps_store_req_t    store_req;
	logic [LEVEL_W-1:0] store_level;
	logic               out_free;
	logic               res_load;
	lmps_out_t          res;
	logic               rsp_valid_q;
	lmps_out_t          rsp_q;

	// The sequencer may hand over a result whenever the output register is empty
	// or is being emptied in this cycle.
	assign out_free = !rsp_valid_q || rsp_ready;

	lmps_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.LEVELS  (LEVELS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req         (req),
		.req_ready   (req_ready),
		.out_free    (out_free),
		.res_load    (res_load),
		.res         (res),
		.store_req   (store_req),
		.store_level (store_level)
	);

	lmps_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (store_req),
		.rd_level (store_level)
	);

	// Output register: valid is control state, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
